// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit: request and
// status codes, sequencer states and the packed transfer payloads.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    REQ_NORM = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4,
    REQ_CMP  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic               is_less;
    logic               is_equal;
    logic        [1:0]  status;
  } out_item_t;

endpackage

// ----- rtl/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two nonzero magnitudes: one shift or one compare-subtract
// per cycle, common factors of two counted and restored at the end.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int DW = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] a_in,
  input  logic [DW-1:0] b_in,
  output logic          done,
  output logic [DW-1:0] g_out
);

  localparam int KW = $clog2(DW);

  logic [DW-1:0] a_r, b_r, g_r;
  logic [KW-1:0] k_r;
  logic          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (a_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      k_r <= '0;
    end else if (busy_r) begin
      priority if (a_r == '0) begin
        g_r <= b_r << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= a_r - b_r;
      end else begin
        b_r <= b_r - a_r;
      end
    end
  end

  assign done  = done_r;
  assign g_out = g_r;

endmodule

// ----- rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int DW = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   rem2;
  logic          fits;

  assign rem2 = {rem_r, q_r[DW-1]};
  assign fits = rem2 >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= CW'(DW);
    end else if (busy_r) begin
      rem_r <= fits ? DW'(rem2 - {1'b0, dvs_r}) : DW'(rem2);
      q_r   <= {q_r[DW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/rational_arithmetic_unit_top.sv -----
// Flow: error and unused requests go straight to the result; compare takes three
// registered products; fraction results take three registered products, a binary
// gcd and two 2*OPERAND_WIDTH-bit divides.
// Throughput: one item at a time; in_stall stays high until the result transfers.
// Reset: synchronous, active low, returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact rational add, subtract, multiply, divide, compare and normalize with
// gcd reduction, sequenced over a multiplier, gcd unit and divider.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_item_t out_data
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;

  function automatic logic [W:0] parse(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return {v[W-1], (v[W-1] ? W'(~v + 1'b1) : v)};
  endfunction

  rau_pkg::state_t    state_r, state_nxt;
  logic [2:0]         req_r;
  logic               an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [W-1:0]       an_r, ad_r, bn_r, bd_r;
  logic [1:0]         mcnt_r;
  logic [DW-1:0]      t1_r, t2_r, t3_r, n_r, d_r;
  logic               neg_r;
  rau_pkg::out_item_t out_r;

  logic [W:0]    pan, pad, pbn, pbd;
  logic          req_unused, zero_den;
  logic [W-1:0]  mx, my;
  logic [DW-1:0] prod;
  logic          s1, s2, dsign, num_neg;
  logic [DW-1:0] sum_mag;
  logic          xn, yn, lt, eq;
  logic          gcd_start, gcd_done, div_start, div_done;
  logic [DW-1:0] g, quot, div_dividend;
  logic [DW-1:0] lim;
  logic          ovf;
  logic [W-1:0]  rn_w;

  // ---- input decode
  assign pan = parse(in_data.a_num);
  assign pad = parse(in_data.a_den);
  assign pbn = parse(in_data.b_num);
  assign pbd = parse(in_data.b_den);
  assign req_unused = in_data.req_type > 3'(rau_pkg::REQ_CMP);
  assign zero_den = (pad[W-1:0] == '0)
      || ((in_data.req_type != 3'(rau_pkg::REQ_NORM)) && (pbd[W-1:0] == '0))
      || ((in_data.req_type == 3'(rau_pkg::REQ_DIV)) && (pbn[W-1:0] == '0));

  // ---- shared multiplier operand select
  always_comb begin
    mx = an_r;
    my = bd_r;
    unique case (mcnt_r)
      2'd0: begin
        mx = an_r;
        if (req_r == 3'(rau_pkg::REQ_NORM))     my = W'(1);
        else if (req_r == 3'(rau_pkg::REQ_MUL)) my = bn_r;
        else                                     my = bd_r;
      end
      2'd1: begin
        mx = bn_r;
        my = ad_r;
      end
      default: begin
        mx = ad_r;
        if (req_r == 3'(rau_pkg::REQ_NORM))     my = W'(1);
        else if (req_r == 3'(rau_pkg::REQ_DIV)) my = bn_r;
        else                                     my = bd_r;
      end
    endcase
  end

  assign prod = DW'(mx) * DW'(my);

  // ---- combine products into signed numerator and denominator
  always_comb begin
    s1    = an_neg_r ^ bd_neg_r;
    s2    = bn_neg_r ^ ad_neg_r ^ (req_r == 3'(rau_pkg::REQ_SUB));
    dsign = ad_neg_r ^ bd_neg_r;
    sum_mag = t1_r;
    num_neg = s1;
    if (req_r == 3'(rau_pkg::REQ_NORM)) begin
      num_neg = an_neg_r;
      dsign   = ad_neg_r;
    end else if (req_r == 3'(rau_pkg::REQ_MUL)) begin
      num_neg = an_neg_r ^ bn_neg_r;
    end else if (req_r == 3'(rau_pkg::REQ_DIV)) begin
      dsign = ad_neg_r ^ bn_neg_r;
    end else if (s1 == s2) begin
      sum_mag = t1_r + t2_r;
    end else if (t1_r >= t2_r) begin
      sum_mag = t1_r - t2_r;
    end else begin
      sum_mag = t2_r - t1_r;
      num_neg = s2;
    end
  end

  // compare: denominators made positive, signs folded into numerators
  assign xn = (an_neg_r ^ ad_neg_r) && (t1_r != '0);
  assign yn = (bn_neg_r ^ bd_neg_r) && (t2_r != '0);
  assign eq = (xn == yn) && (t1_r == t2_r);
  always_comb begin
    priority if (xn != yn) lt = xn;
    else if (xn)           lt = t1_r > t2_r;
    else                   lt = t1_r < t2_r;
  end

  // ---- overflow check on the reduced fraction
  assign lim  = DW'(1) << (W - 1);
  assign ovf  = (d_r > lim - 1'b1) || (neg_r ? (n_r > lim) : (n_r > lim - 1'b1));
  assign rn_w = neg_r ? W'(~n_r + 1'b1) : n_r[W-1:0];

  rau_gcd #(.DW(DW)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (sum_mag),
    .b_in  (t3_r),
    .done  (gcd_done),
    .g_out (g)
  );

  rau_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g),
    .done     (div_done),
    .quot     (quot)
  );

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::S_IDLE:  if (in_valid) state_nxt = (req_unused || zero_den) ?
                                                  rau_pkg::S_OUT : rau_pkg::S_MUL;
      rau_pkg::S_MUL:   if (mcnt_r == 2'd2) state_nxt = rau_pkg::S_COMB;
      rau_pkg::S_COMB: begin
        if (req_r == 3'(rau_pkg::REQ_CMP)) state_nxt = rau_pkg::S_OUT;
        else if (sum_mag == '0)            state_nxt = rau_pkg::S_CHECK;
        else                               state_nxt = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD:   if (gcd_done) state_nxt = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN:  if (div_done) state_nxt = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD:  if (div_done) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: state_nxt = rau_pkg::S_OUT;
      rau_pkg::S_OUT:   if (!out_stall) state_nxt = rau_pkg::S_IDLE;
      default:          state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != rau_pkg::S_IDLE);
    out_valid    = (state_r == rau_pkg::S_OUT);
    gcd_start    = (state_r == rau_pkg::S_COMB) && (req_r != 3'(rau_pkg::REQ_CMP))
                   && (sum_mag != '0);
    div_start    = ((state_r == rau_pkg::S_GCD) && gcd_done)
                   || ((state_r == rau_pkg::S_DIVN) && div_done);
    div_dividend = (state_r == rau_pkg::S_GCD) ? n_r : d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rau_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          req_r    <= in_data.req_type;
          an_neg_r <= pan[W];
          ad_neg_r <= pad[W];
          bn_neg_r <= pbn[W];
          bd_neg_r <= pbd[W];
          an_r     <= pan[W-1:0];
          ad_r     <= pad[W-1:0];
          bn_r     <= pbn[W-1:0];
          bd_r     <= pbd[W-1:0];
          mcnt_r   <= 2'd0;
          out_r    <= '{res_num: '0, res_den: '0, is_less: 1'b0, is_equal: 1'b0,
                        status: (zero_den && !req_unused) ? 2'(rau_pkg::ST_ZERO_DEN)
                                                          : 2'(rau_pkg::ST_OK)};
        end
      end
      rau_pkg::S_MUL: begin
        unique case (mcnt_r)
          2'd0:    t1_r <= prod;
          2'd1:    t2_r <= prod;
          default: t3_r <= prod;
        endcase
        mcnt_r <= mcnt_r + 1'b1;
      end
      rau_pkg::S_COMB: begin
        if (req_r == 3'(rau_pkg::REQ_CMP)) begin
          out_r <= '{res_num: '0, res_den: '0, is_less: lt, is_equal: eq,
                     status: 2'(rau_pkg::ST_OK)};
        end else if (sum_mag == '0) begin
          n_r   <= '0;
          d_r   <= DW'(1);
          neg_r <= 1'b0;
        end else begin
          n_r   <= sum_mag;
          d_r   <= t3_r;
          neg_r <= num_neg ^ dsign;
        end
      end
      rau_pkg::S_DIVN: if (div_done) n_r <= quot;
      rau_pkg::S_DIVD: if (div_done) d_r <= quot;
      rau_pkg::S_CHECK: begin
        if (ovf) begin
          out_r <= '{res_num: '0, res_den: '0, is_less: 1'b0, is_equal: 1'b0,
                     status: 2'(rau_pkg::ST_OVERFLOW)};
        end else begin
          out_r <= '{res_num: 32'(signed'(rn_w)), res_den: 31'(d_r[W-2:0]),
                     is_less: 1'b0, is_equal: 1'b0, status: 2'(rau_pkg::ST_OK)};
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

  // ---- checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != 2'(rau_pkg::ST_OK))) |->
      (out_data.res_num == '0 && out_data.res_den == '0
       && !out_data.is_less && !out_data.is_equal))
    else $error("error status with nonzero result fields");

  a_zero_den_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == 2'(rau_pkg::ST_OK)) && (out_data.res_num == '0)
     && (req_r <= 3'(rau_pkg::REQ_DIV))) |-> (out_data.res_den == 31'd1))
    else $error("zero result not in 0/1 form");

  a_div_after_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rau_pkg::S_GCD && gcd_done) |=> (state_r == rau_pkg::S_DIVN))
    else $error("gcd completion did not start numerator divide");

endmodule
